// ===== rtl/twra_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// twra_pkg
// Shared constants for the time-windowed response average block.
// ----------------------------------------------------------------------------
package twra_pkg;

    localparam int SAMPLES  = 16;
    localparam int IdxW     = $clog2(SAMPLES);
    localparam int RankW    = $clog2(SAMPLES + 1);

    localparam int SampleW  = 32;
    localparam int StampW   = 32;
    localparam int EntryW   = SampleW + StampW;

    localparam int PeriodW  = 16;
    localparam int MsPerSec = 1000;
    localparam int SpanW    = PeriodW + $clog2(MsPerSec);

    // weighted denominator, the largest divisor used
    localparam int Denom    = (SAMPLES * (SAMPLES + 1)) / 2;
    localparam int DenW     = $clog2(Denom + 1);

    // divider retires DivBits quotient bits per cycle
    localparam int DivBits  = 4;
    localparam int DivIters = (SampleW + DenW + DivBits - 1) / DivBits;
    localparam int AccW     = DivIters * DivBits;
    localparam int DivCntW  = $clog2(DivIters);

    localparam int CfgIdxW  = 2;
    localparam int CfgDataW = 16;

    localparam logic [CfgIdxW-1:0] CfgPeriod = CfgIdxW'(0);
    localparam logic [CfgIdxW-1:0] CfgMethod = CfgIdxW'(1);

    localparam logic ModeInsert = 1'b0;
    localparam logic ModeQuery  = 1'b1;

    localparam logic MethodPlain    = 1'b0;
    localparam logic MethodWeighted = 1'b1;

endpackage
`default_nettype wire

// ===== rtl/twra_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// twra_div
// Restoring divider by a narrow divisor, several quotient bits per cycle.
// ----------------------------------------------------------------------------
module twra_div (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic [twra_pkg::AccW-1:0]     dividend,
    input  wire logic [twra_pkg::DenW-1:0]     divisor,
    output logic                               done,
    output logic [twra_pkg::SampleW-1:0]       quotient
);

    logic                            busy_reg, busy_next;
    logic                            done_reg, done_next;
    logic [twra_pkg::DivCntW-1:0]    cnt_reg, cnt_next;
    logic [twra_pkg::AccW-1:0]       dvd_reg, dvd_next;
    logic [twra_pkg::DenW-1:0]       rem_reg, rem_next;
    logic [twra_pkg::DenW-1:0]       den_reg, den_next;
    logic [twra_pkg::AccW-1:0]       dvd_step;
    logic [twra_pkg::DenW-1:0]       rem_step;

    always_comb begin
        logic [twra_pkg::DenW:0] rem_w;
        dvd_step = dvd_reg;
        rem_step = rem_reg;
        for (int i = 0; i < twra_pkg::DivBits; i++) begin
            rem_w    = {rem_step, dvd_step[twra_pkg::AccW-1]};
            dvd_step = {dvd_step[twra_pkg::AccW-2:0], 1'b0};
            if (rem_w >= {1'b0, den_reg}) begin
                rem_w       = rem_w - {1'b0, den_reg};
                dvd_step[0] = 1'b1;
            end
            rem_step = rem_w[twra_pkg::DenW-1:0];
        end
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = dividend;
            rem_next  = '0;
            den_next  = divisor;
        end else if (busy_reg) begin
            dvd_next = dvd_step;
            rem_next = rem_step;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == twra_pkg::DivCntW'(twra_pkg::DivIters - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done     = done_reg;
    assign quotient = dvd_reg[twra_pkg::SampleW-1:0];

endmodule
`default_nettype wire

// ===== rtl/time_windowed_response_average.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// time_windowed_response_average
// Ring of recent response times with arrival stamps; a query averages the
// entries still inside the age window, plain or rank weighted.
// ----------------------------------------------------------------------------
// insert: no result, next transaction accepted in the next cycle
// query: result after the ring walk and the division;
//   one ring entry read per cycle, then DivBits quotient bits per divider cycle
// a new transaction is taken once the result is in the output register
// synchronous active-low reset clears control, config and the entry valid bits;
//   entries never written read as zero
// ----------------------------------------------------------------------------
module time_windowed_response_average (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,

    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [twra_pkg::CfgIdxW-1:0]    cfg_index,
    input  wire logic [twra_pkg::CfgDataW-1:0]   cfg_data,

    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic                            s_mode,
    input  wire logic [31:0]                     s_sample_ms,
    input  wire logic [31:0]                     s_now_ms,

    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic [31:0]                          m_average_ms
);

    typedef enum logic [4:0] {
        StIdle  = 5'b00001,
        StWalk  = 5'b00010,
        StDrain = 5'b00100,
        StDiv   = 5'b01000,
        StDone  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [twra_pkg::PeriodW-1:0]  period_reg;
    logic                          method_reg;
    logic [twra_pkg::SpanW-1:0]    span_reg;

    logic [twra_pkg::EntryW-1:0]   mem [twra_pkg::SAMPLES];
    logic [twra_pkg::SAMPLES-1:0]  valid_reg;
    logic [twra_pkg::IdxW-1:0]     oldest_reg;
    logic [twra_pkg::IdxW-1:0]     walk_cnt_reg;
    logic [twra_pkg::IdxW-1:0]     rd_addr;
    logic [twra_pkg::IdxW:0]       addr_sum;
    logic                          rd_en;

    logic                          a_vld_reg;
    logic                          a_ok_reg;
    logic [twra_pkg::RankW-1:0]    a_rank_reg;
    logic [twra_pkg::EntryW-1:0]   rd_data_reg;

    logic                          b_vld_reg;
    logic [twra_pkg::AccW-1:0]     term_reg, term_next;
    logic [twra_pkg::AccW-1:0]     acc_reg;

    logic [31:0]                   now_reg;
    logic [twra_pkg::DenW-1:0]     den_reg;

    logic                          m_valid_reg;
    logic [31:0]                   m_average_reg;

    logic                          in_fire;
    logic                          insert_fire;
    logic                          query_fire;
    logic                          cfg_fire;
    logic                          walk_last;
    logic                          drained;
    logic                          out_free;
    logic                          div_start;
    logic                          div_done;
    logic [31:0]                   div_quot;

    assign cfg_ready   = 1'b1;
    assign s_ready     = (state_reg == StIdle);
    assign in_fire     = s_valid && s_ready;
    assign insert_fire = in_fire && (s_mode == twra_pkg::ModeInsert);
    assign query_fire  = in_fire && (s_mode == twra_pkg::ModeQuery);
    assign cfg_fire    = cfg_valid && cfg_ready;
    assign walk_last   = (walk_cnt_reg == twra_pkg::IdxW'(twra_pkg::SAMPLES - 1));
    assign drained     = !a_vld_reg && !b_vld_reg;
    assign out_free    = !m_valid_reg || m_ready;
    assign div_start   = (state_reg == StDrain) && drained;

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg <= twra_pkg::PeriodW'(1);
            method_reg <= twra_pkg::MethodPlain;
        end else if (cfg_fire) begin
            case (cfg_index)
                twra_pkg::CfgPeriod: period_reg <= cfg_data[twra_pkg::PeriodW-1:0];
                twra_pkg::CfgMethod: method_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        span_reg <= twra_pkg::SpanW'(period_reg) * twra_pkg::SpanW'(twra_pkg::MsPerSec);
    end

    // ring address, oldest first
    assign addr_sum = {1'b0, oldest_reg} + {1'b0, walk_cnt_reg};
    always_comb begin
        if (addr_sum >= (twra_pkg::IdxW + 1)'(twra_pkg::SAMPLES)) begin
            rd_addr = twra_pkg::IdxW'(addr_sum - (twra_pkg::IdxW + 1)'(twra_pkg::SAMPLES));
        end else begin
            rd_addr = addr_sum[twra_pkg::IdxW-1:0];
        end
    end
    assign rd_en = (state_reg == StWalk);

    always_ff @(posedge aclk) begin
        if (insert_fire) begin
            mem[oldest_reg] <= {s_now_ms, s_sample_ms};
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= '0;
            oldest_reg <= '0;
        end else if (insert_fire) begin
            valid_reg[oldest_reg] <= 1'b1;
            if (oldest_reg == twra_pkg::IdxW'(twra_pkg::SAMPLES - 1)) begin
                oldest_reg <= '0;
            end else begin
                oldest_reg <= oldest_reg + 1'b1;
            end
        end
    end

    // window test and weighting
    always_comb begin
        logic [32:0]                   limit;
        logic [31:0]                   sample;
        logic [twra_pkg::RankW-1:0]    weight;
        logic [31+twra_pkg::RankW:0]   prod;
        limit  = {1'b0, rd_data_reg[twra_pkg::EntryW-1:twra_pkg::SampleW]}
               + 33'(span_reg);
        sample = a_ok_reg ? rd_data_reg[twra_pkg::SampleW-1:0] : '0;
        weight = (method_reg == twra_pkg::MethodWeighted) ? a_rank_reg
                                                          : twra_pkg::RankW'(1);
        prod   = sample * weight;
        if (limit > {1'b0, now_reg}) begin
            term_next = twra_pkg::AccW'(prod);
        end else begin
            term_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
        end else begin
            a_vld_reg <= rd_en;
            b_vld_reg <= a_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        a_ok_reg   <= valid_reg[rd_addr];
        a_rank_reg <= twra_pkg::RankW'(walk_cnt_reg) + 1'b1;
        term_reg   <= term_next;
        if (query_fire) begin
            acc_reg <= '0;
            now_reg <= s_now_ms;
            den_reg <= (method_reg == twra_pkg::MethodWeighted)
                     ? twra_pkg::DenW'(twra_pkg::Denom)
                     : twra_pkg::DenW'(twra_pkg::SAMPLES);
        end else if (b_vld_reg) begin
            acc_reg <= acc_reg + term_reg;
        end
    end

    twra_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (acc_reg),
        .divisor  (den_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    // sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            StIdle:  if (query_fire) state_next = StWalk;
            StWalk:  if (walk_last) state_next = StDrain;
            StDrain: if (drained) state_next = StDiv;
            StDiv:   if (div_done) state_next = StDone;
            StDone:  if (out_free) state_next = StIdle;
            default: state_next = StIdle;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= StIdle;
            walk_cnt_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (query_fire) begin
                walk_cnt_reg <= '0;
            end else if (rd_en) begin
                walk_cnt_reg <= walk_cnt_reg + 1'b1;
            end
            if (state_reg == StDone && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == StDone && out_free) begin
            m_average_reg <= div_quot;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_average_ms = m_average_reg;

endmodule
`default_nettype wire

// ===== rtl/twra_chk.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// twra_chk
// Port-level checks for the time-windowed response average block.
// ----------------------------------------------------------------------------
module twra_chk (
    input wire logic                            aclk,
    input wire logic                            aresetn,
    input wire logic                            cfg_valid,
    input wire logic                            cfg_ready,
    input wire logic [twra_pkg::CfgIdxW-1:0]    cfg_index,
    input wire logic [twra_pkg::CfgDataW-1:0]   cfg_data,
    input wire logic                            s_valid,
    input wire logic                            s_ready,
    input wire logic                            s_mode,
    input wire logic [31:0]                     s_sample_ms,
    input wire logic [31:0]                     s_now_ms,
    input wire logic                            m_valid,
    input wire logic                            m_ready,
    input wire logic [31:0]                     m_average_ms
);

    // a stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_average_ms))
        else $error("result changed while stalled");

    // a query keeps the block busy
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_mode == twra_pkg::ModeQuery |=> !s_ready)
        else $error("input taken during query");

    // an insert never blocks the next transaction
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_mode == twra_pkg::ModeInsert |=> s_ready)
        else $error("insert stalled input");

    // a result appears only at the end of a query
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result without a query");

endmodule

bind time_windowed_response_average twra_chk u_twra_chk (.*);
`default_nettype wire
